>>> rtl/core/dshp_pkg.sv
package dshp_pkg;

  localparam int PARTITIONS = 12;

  localparam int HASH_W = 64;
  localparam int CHAR_W = 8;
  localparam int ID_W = 32;
  localparam int PART_W = (PARTITIONS > 1) ? $clog2(PARTITIONS) : 1;

  localparam logic [HASH_W-1:0] HASH_SEED = 64'd5381;
  localparam logic [CHAR_W-1:0] DOT_CHAR = 8'h2E;

  // residue reduction: weighted nibble sum, then reciprocal multiply
  localparam int NIBBLES = HASH_W / 4;
  localparam int SUM_MAX = NIBBLES * 15 * (PARTITIONS - 1);
  localparam int SUM_W = (SUM_MAX > 1) ? $clog2(SUM_MAX + 1) : 1;
  localparam int RECIP_S = SUM_W + 8;
  localparam logic [RECIP_S:0] RECIP_M =
    (RECIP_S + 1)'(((longint'(1) << RECIP_S) + PARTITIONS - 1) / PARTITIONS);
  localparam int PROD_W = SUM_W + RECIP_S + 1;

  typedef struct packed {
    logic              vld;
    logic [HASH_W-1:0] hash;
  } hash_xfer_t;

  // 16^k mod PARTITIONS
  function automatic int nib_weight(input int k);
    int w;
    w = 1 % PARTITIONS;
    for (int j = 0; j < k; j++) begin
      w = (w * 16) % PARTITIONS;
    end
    return w;
  endfunction

endpackage

>>> rtl/core/dshp_in_if.sv
interface dshp_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [dshp_pkg::CHAR_W-1:0]  character;
  logic                                last_char;
  logic                                empty_name;

  modport source (output valid, output character, output last_char, output empty_name,
                  input ready);
  modport sink (input valid, input character, input last_char, input empty_name,
                output ready);
endinterface

>>> rtl/core/dshp_out_if.sv
interface dshp_out_if;
  logic                         valid;
  logic                         ready;
  logic [dshp_pkg::HASH_W-1:0]  name_hash;
  logic [dshp_pkg::PART_W-1:0]  partition;
  logic [dshp_pkg::ID_W-1:0]    assigned_id;
  logic                         id_overflow;

  modport source (output valid, output name_hash, output partition, output assigned_id,
                  output id_overflow, input ready);
  modport sink (input valid, input name_hash, input partition, input assigned_id,
                input id_overflow, output ready);
endinterface

>>> rtl/core/dshp_front.sv
module dshp_front (
  input  logic                  clk,
  input  logic                  rst_n,
  dshp_in_if.sink               in_ch,
  input  logic                  q_full,
  output dshp_pkg::hash_xfer_t  push
);
  import dshp_pkg::*;

  logic [HASH_W-1:0] seg_r, seg_nxt;
  logic [HASH_W-1:0] fin_r, fin_nxt;
  logic              dot_r, dot_nxt;
  logic [HASH_W-1:0] base;
  logic [HASH_W-1:0] ext;
  logic [HASH_W-1:0] seg_upd;
  logic [HASH_W-1:0] fin_upd;
  logic              dot_upd;
  logic              is_dot;
  logic              acc;

  assign in_ch.ready = !q_full;
  assign acc = in_ch.valid && in_ch.ready;

  assign is_dot = (in_ch.character == DOT_CHAR);
  assign ext = HASH_W'(in_ch.character);
  assign base = is_dot ? HASH_SEED : seg_r;
  // times 37 as shift-add
  assign seg_upd = (base << 5) + (base << 2) + base + ext;
  assign fin_upd = is_dot ? seg_r : fin_r;
  assign dot_upd = is_dot || dot_r;

  always_comb begin
    seg_nxt = seg_r;
    fin_nxt = fin_r;
    dot_nxt = dot_r;
    push.vld = 1'b0;
    push.hash = '0;
    if (acc) begin
      if (in_ch.empty_name) begin
        push.vld = 1'b1;
        seg_nxt = HASH_SEED;
        fin_nxt = '0;
        dot_nxt = 1'b0;
      end else if (in_ch.last_char) begin
        push.vld = 1'b1;
        push.hash = dot_upd ? fin_upd : seg_upd;
        seg_nxt = HASH_SEED;
        fin_nxt = '0;
        dot_nxt = 1'b0;
      end else begin
        seg_nxt = seg_upd;
        fin_nxt = fin_upd;
        dot_nxt = dot_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seg_r <= HASH_SEED;
      fin_r <= '0;
      dot_r <= 1'b0;
    end else begin
      seg_r <= seg_nxt;
      fin_r <= fin_nxt;
      dot_r <= dot_nxt;
    end
  end

endmodule

>>> rtl/core/dshp_fifo.sv
module dshp_fifo (
  input  logic                  clk,
  input  logic                  rst_n,
  input  dshp_pkg::hash_xfer_t  push,
  output logic                  full,
  output dshp_pkg::hash_xfer_t  pop,
  input  logic                  pop_ready
);
  import dshp_pkg::*;

  logic [HASH_W-1:0] mem_r [2];
  logic              wr_ptr_r, wr_ptr_nxt;
  logic              rd_ptr_r, rd_ptr_nxt;
  logic [1:0]        cnt_r, cnt_nxt;
  logic              do_pop;

  assign full = (cnt_r == 2'd2);
  assign pop.vld = (cnt_r != 2'd0);
  assign pop.hash = mem_r[rd_ptr_r];
  assign do_pop = pop.vld && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt = cnt_r;
    if (push.vld) begin
      wr_ptr_nxt = !wr_ptr_r;
    end
    if (do_pop) begin
      rd_ptr_nxt = !rd_ptr_r;
    end
    case ({push.vld, do_pop})
      2'b10:   cnt_nxt = cnt_r + 2'd1;
      2'b01:   cnt_nxt = cnt_r - 2'd1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (push.vld) begin
      mem_r[wr_ptr_r] <= push.hash;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

>>> rtl/core/dshp_back.sv
module dshp_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  dshp_pkg::hash_xfer_t  pop,
  output logic                  pop_ready,
  dshp_out_if.source            out_ch
);
  import dshp_pkg::*;

  logic              a_v_r;
  logic [HASH_W-1:0] a_hash_r;
  logic [SUM_W-1:0]  a_sum_r;
  logic [SUM_W-1:0]  sum_nxt;

  logic              b_v_r;
  logic [HASH_W-1:0] b_hash_r;
  logic [SUM_W-1:0]  b_sum_r;
  logic [SUM_W-1:0]  b_q_r;
  logic [PROD_W-1:0] prod;

  logic [SUM_W-1:0]  rem;
  logic [PART_W-1:0] part;
  logic [ID_W-1:0]   cnt;
  logic [ID_W:0]     cnt_add;

  logic [ID_W-1:0]   ctr_r [PARTITIONS];

  logic              out_v_r;
  logic [HASH_W-1:0] out_hash_r;
  logic [PART_W-1:0] out_part_r;
  logic [ID_W-1:0]   out_id_r;
  logic              out_ovf_r;

  logic              en_a;
  logic              en_b;
  logic              en_c;

  assign en_c = !out_v_r || out_ch.ready;
  assign en_b = !b_v_r || en_c;
  assign en_a = !a_v_r || en_b;
  assign pop_ready = en_a;

  // weighted nibble sum keeps the residue
  always_comb begin
    sum_nxt = '0;
    for (int i = 0; i < NIBBLES; i++) begin
      sum_nxt = sum_nxt + SUM_W'(SUM_W'(pop.hash[4*i +: 4]) * SUM_W'(nib_weight(i)));
    end
  end

  assign prod = PROD_W'(a_sum_r) * PROD_W'(RECIP_M);
  assign rem = b_sum_r - SUM_W'(b_q_r * SUM_W'(PARTITIONS));
  assign part = rem[PART_W-1:0];
  assign cnt = ctr_r[part];
  assign cnt_add = {1'b0, cnt} + (ID_W + 1)'(PARTITIONS);

  always_ff @(posedge clk) begin
    if (en_a && pop.vld) begin
      a_hash_r <= pop.hash;
      a_sum_r <= sum_nxt;
    end
    if (en_b && a_v_r) begin
      b_hash_r <= a_hash_r;
      b_sum_r <= a_sum_r;
      b_q_r <= prod[RECIP_S +: SUM_W];
    end
    if (en_c && b_v_r) begin
      out_hash_r <= b_hash_r;
      out_part_r <= part;
      out_id_r <= cnt;
      out_ovf_r <= cnt_add[ID_W];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
      out_v_r <= 1'b0;
      for (int i = 0; i < PARTITIONS; i++) begin
        ctr_r[i] <= ID_W'(i);
      end
    end else begin
      if (en_a) begin
        a_v_r <= pop.vld;
      end
      if (en_b) begin
        b_v_r <= a_v_r;
      end
      if (en_c) begin
        out_v_r <= b_v_r;
      end
      if (en_c && b_v_r && !cnt_add[ID_W]) begin
        ctr_r[part] <= cnt_add[ID_W-1:0];
      end
    end
  end

  assign out_ch.valid = out_v_r;
  assign out_ch.name_hash = out_hash_r;
  assign out_ch.partition = out_part_r;
  assign out_ch.assigned_id = out_id_r;
  assign out_ch.id_overflow = out_ovf_r;

endmodule

>>> rtl/core/dotted_segment_hash_partitioner_core.sv
// channel  | dir | handshake       | payload
// in_ch    | in  | valid / ready   | character, last_char, empty_name
// out_ch   | out | valid / ready   | name_hash, partition, assigned_id, id_overflow
//
// one character per cycle while in_ready holds; hashed in the cycle it is accepted
// after its last character a result is registered in the queue, two residue stages
// and the counter stage; results follow one per cycle while out_ch.ready holds
// synchronous active-low reset clears the name state, queue and pipeline valids and
// loads each partition counter with its own index
// a two-entry queue parts front and back; in_ready drops only while it is full
module dotted_segment_hash_partitioner_core (
  input  logic      clk,
  input  logic      rst_n,
  dshp_in_if.sink   in_ch,
  dshp_out_if.source out_ch
);
  import dshp_pkg::*;

  hash_xfer_t push;
  hash_xfer_t pop;
  logic       q_full;
  logic       pop_ready;

  dshp_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .q_full (q_full),
    .push   (push)
  );

  dshp_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (q_full),
    .pop       (pop),
    .pop_ready (pop_ready)
  );

  dshp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop       (pop),
    .pop_ready (pop_ready),
    .out_ch    (out_ch)
  );

endmodule
